// ----- rtl/epot_pkg.sv -----
// ============================================================================
// epot_pkg: shared definitions for the edge period oscillator trim
// Field widths, register indexes and reset values of the trim loop.
// ============================================================================
`default_nettype none

package epot_pkg;

    localparam int unsigned STAMP_W   = 32;
    localparam int unsigned DUTY_W    = 15;
    localparam int unsigned REJECT_W  = 16;
    localparam int unsigned ILIMIT_W  = 15;
    localparam int unsigned DBAND_W   = 15;
    localparam int unsigned GAIN_W    = 8;
    localparam int unsigned INTEG_W   = 16;
    // An accepted error is bounded by the reject limit, so 17 signed bits hold it.
    localparam int unsigned SERR_W    = REJECT_W + 1;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;
    localparam int unsigned OUT_TDATA_W = 48;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REJECT_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_GAIN      = 3'd5;

    // Reset values.
    localparam logic [STAMP_W-1:0]  RST_EXPECTED_PERIOD = 32'd0;
    localparam logic [DUTY_W-1:0]   RST_DUTY_MAX        = 15'd1999;
    localparam logic [REJECT_W-1:0] RST_REJECT_LIMIT    = 16'd1000;
    localparam logic [ILIMIT_W-1:0] RST_INTEGRAL_LIMIT  = 15'd100;
    localparam logic [DBAND_W-1:0]  RST_DEADBAND        = 15'd5;
    localparam logic [GAIN_W-1:0]   RST_ERROR_GAIN      = 8'd10;
    localparam logic [DUTY_W-1:0]   RST_DUTY_SETTING    = 15'd999;

    // Result of one edge as it leaves the loop.
    typedef struct packed {
        logic                       rejected;
        logic signed [STAMP_W-1:0]  period_error;
        logic [DUTY_W-1:0]          duty;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/edge_period_oscillator_trim.sv -----
// ============================================================================
// edge_period_oscillator_trim: frame edge period to PWM duty trim loop
// Measures the period between frame start edges, rejects outliers, keeps a
// clamped error integral and steers a PWM duty by proportional gain and nudge.
// ============================================================================
// Path: an input beat passes the period error register, then the duty
// update into the result register. Throughput: one edge per cycle while
// m_axis_tready does not stall the result; the integral and duty feedback
// closes within the update stage, so back-to-back edges see each other's state.
// Reset: synchronous, active low; clears both stages, restores all
// configuration registers and sets the duty to 999 and the integral to zero.
`default_nettype none

module edge_period_oscillator_trim (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input stream: tdata = edge_timestamp[31:0]
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [epot_pkg::STAMP_W-1:0]        s_axis_tdata,
    // Result stream: tdata = duty_value[14:0], period_error[46:15], zero[47]
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic [epot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser = edge_rejected[0]
    output logic                                m_axis_tuser,
    // Configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [epot_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [epot_pkg::CFG_DAT_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [epot_pkg::STAMP_W-1:0]   r_expected_period;
    logic [epot_pkg::DUTY_W-1:0]    r_duty_max;
    logic [epot_pkg::REJECT_W-1:0]  r_reject_limit;
    logic [epot_pkg::ILIMIT_W-1:0]  r_integral_limit;
    logic [epot_pkg::DBAND_W-1:0]   r_deadband;
    logic [epot_pkg::GAIN_W-1:0]    r_error_gain;

    // Loop state.
    logic [epot_pkg::STAMP_W-1:0]        r_prev_stamp;
    logic signed [epot_pkg::INTEG_W-1:0] r_integral;
    logic [epot_pkg::DUTY_W-1:0]         r_duty;

    // Stage one: period error of the edge.
    logic                                r_s1_valid;
    logic signed [epot_pkg::STAMP_W-1:0] r_s1_err;
    logic [epot_pkg::STAMP_W-1:0]        n_s1_err;

    // Result register.
    logic              r_out_valid;
    epot_pkg::t_result r_out;

    logic in_beat;
    logic s2_ready;
    logic s2_move;
    logic cfg_beat;

    assign o_cfg_ready   = 1'b1;
    assign cfg_beat      = i_cfg_valid & o_cfg_ready;
    assign s2_ready      = ~r_out_valid | m_axis_tready;
    assign s2_move       = r_s1_valid & s2_ready;
    assign s_axis_tready = ~r_s1_valid | s2_ready;
    assign in_beat       = s_axis_tvalid & s_axis_tready;

    // Wrapping period minus the expected interval, as one three-input add.
    assign n_s1_err = s_axis_tdata - r_prev_stamp - r_expected_period;

    // ------------------------------------------------------------------
    // Stage two: reject test, integral, nudge and duty update
    // ------------------------------------------------------------------
    logic signed [epot_pkg::STAMP_W:0]     err_x;
    logic signed [epot_pkg::STAMP_W:0]     rlim_x;
    logic                                  rejected;
    logic signed [epot_pkg::SERR_W-1:0]    err_s;
    logic signed [epot_pkg::INTEG_W+1:0]   acc;
    logic signed [epot_pkg::INTEG_W+1:0]   ilim;
    logic signed [epot_pkg::INTEG_W+1:0]   acc_c;
    logic signed [epot_pkg::INTEG_W+1:0]   dband;
    logic signed [1:0]                     nudge;
    logic signed [epot_pkg::SERR_W+epot_pkg::GAIN_W:0] prod;
    logic signed [epot_pkg::SERR_W+epot_pkg::GAIN_W+2:0] duty_w;
    logic [epot_pkg::DUTY_W-1:0]           n_duty;
    logic signed [epot_pkg::INTEG_W-1:0]   n_integral;

    always_comb begin
        err_x  = {r_s1_err[epot_pkg::STAMP_W-1], r_s1_err};
        rlim_x = $signed({{(epot_pkg::STAMP_W+1-epot_pkg::REJECT_W){1'b0}}, r_reject_limit});
        rejected = (err_x > rlim_x) || (err_x < -rlim_x);

        // Only meaningful when the edge is not rejected.
        err_s = r_s1_err[epot_pkg::SERR_W-1:0];
        acc   = {{2{r_integral[epot_pkg::INTEG_W-1]}}, r_integral}
              + {err_s[epot_pkg::SERR_W-1], err_s};
        ilim  = $signed({3'b000, r_integral_limit});
        acc_c = acc;
        if (acc > ilim) begin
            acc_c = ilim;
        end
        if (acc < -ilim) begin
            acc_c = -ilim;
        end
        n_integral = acc_c[epot_pkg::INTEG_W-1:0];

        dband = $signed({3'b000, r_deadband});
        nudge = 2'sd0;
        if (acc_c > dband) begin
            nudge = 2'sd1;
        end
        if (acc_c < -dband) begin
            nudge = -2'sd1;
        end

        prod   = $signed({1'b0, r_error_gain}) * err_s;
        duty_w = $signed({{(epot_pkg::SERR_W+epot_pkg::GAIN_W+3-epot_pkg::DUTY_W){1'b0}}, r_duty})
               - {{2{prod[epot_pkg::SERR_W+epot_pkg::GAIN_W]}}, prod}
               - {{(epot_pkg::SERR_W+epot_pkg::GAIN_W+1){nudge[1]}}, nudge};
        if (duty_w < 0) begin
            n_duty = '0;
        end else if (duty_w > $signed({{(epot_pkg::SERR_W+epot_pkg::GAIN_W+3-epot_pkg::DUTY_W){1'b0}},
                                       r_duty_max})) begin
            n_duty = r_duty_max;
        end else begin
            n_duty = duty_w[epot_pkg::DUTY_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_period <= epot_pkg::RST_EXPECTED_PERIOD;
            r_duty_max        <= epot_pkg::RST_DUTY_MAX;
            r_reject_limit    <= epot_pkg::RST_REJECT_LIMIT;
            r_integral_limit  <= epot_pkg::RST_INTEGRAL_LIMIT;
            r_deadband        <= epot_pkg::RST_DEADBAND;
            r_error_gain      <= epot_pkg::RST_ERROR_GAIN;
        end else if (cfg_beat) begin
            case (i_cfg_index)
                epot_pkg::REG_EXPECTED_PERIOD: r_expected_period <= i_cfg_data;
                epot_pkg::REG_DUTY_MAX: r_duty_max <= i_cfg_data[epot_pkg::DUTY_W-1:0];
                epot_pkg::REG_REJECT_LIMIT: r_reject_limit <= i_cfg_data[epot_pkg::REJECT_W-1:0];
                epot_pkg::REG_INTEGRAL_LIMIT: begin
                    r_integral_limit <= i_cfg_data[epot_pkg::ILIMIT_W-1:0];
                end
                epot_pkg::REG_DEADBAND: r_deadband <= i_cfg_data[epot_pkg::DBAND_W-1:0];
                epot_pkg::REG_ERROR_GAIN: r_error_gain <= i_cfg_data[epot_pkg::GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_prev_stamp <= '0;
            r_integral   <= '0;
            r_duty       <= epot_pkg::RST_DUTY_SETTING;
        end else begin
            if (in_beat) begin
                r_s1_valid   <= 1'b1;
                r_prev_stamp <= s_axis_tdata;
            end else if (s2_move) begin
                r_s1_valid <= 1'b0;
            end

            if (s2_move) begin
                r_out_valid <= 1'b1;
                if (!rejected) begin
                    r_integral <= n_integral;
                    r_duty     <= n_duty;
                end
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_err <= n_s1_err;
        end
        if (s2_move) begin
            r_out.rejected     <= rejected;
            r_out.period_error <= r_s1_err;
            r_out.duty         <= rejected ? r_duty : n_duty;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.period_error, r_out.duty};
    assign m_axis_tuser  = r_out.rejected;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s1_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_result_is_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.duty == r_duty)
        else $error("reported duty differs from the duty setting");

    a_reject_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_move && rejected |=> r_duty == $past(r_duty) && r_integral == $past(r_integral))
        else $error("rejected edge changed the loop state");

    a_accept_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.rejected |-> r_out.duty <= r_duty_max)
        else $error("accepted edge left duty above its maximum");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_valid && r_out_valid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
